[sv/nearest_site_pixel_classifier_macros.svh]
// Assertion macros for the nearest-site pixel classifier RTL.
// Each macro assumes clk and arst_n are in scope; no other dependencies.
`ifndef NEAREST_SITE_PIXEL_CLASSIFIER_MACROS_SVH
`define NEAREST_SITE_PIXEL_CLASSIFIER_MACROS_SVH

`ifndef SYNTH
// expression must hold at every clock edge out of reset
`define NSC_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("nsc assertion failed");
// antecedent in this cycle implies consequent in the same cycle
`define NSC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nsc assertion failed");
// antecedent in this cycle implies consequent in the next cycle
`define NSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nsc assertion failed");
`else
`define NSC_ASSERT_ALWAYS(lbl, expr)
`define NSC_ASSERT_SAME(lbl, ante, cons)
`define NSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/nsc_pkg.sv]
// Types and constants for the nearest-site pixel classifier.
// Used by nsc_cell, nsc_out_buf and the top level; no dependencies.
package nsc_pkg;

	localparam int COORD_W = 11;
	localparam int SLOT_W = 6;
	localparam int COLOR_W = 24;
	localparam int DIST_W = 23;   // 2 * 2047^2 fits without loss
	localparam int SQ_W = 2 * COORD_W;
	localparam int COUNT_W = 7;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	typedef struct packed {
		logic cmd;
		logic [SLOT_W-1:0] site_slot;
		logic [COORD_W-1:0] site_x;
		logic [COORD_W-1:0] site_y;
		logic [COLOR_W-1:0] site_color;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} nsc_in_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic [SLOT_W-1:0] nearest_slot;
		logic [DIST_W-1:0] nearest_distance;
	} nsc_out_t;

	// beat travelling down the cell chain with the running best match
	typedef struct packed {
		logic valid;
		nsc_in_t item;
		logic [DIST_W-1:0] best_dist;
		logic [SLOT_W-1:0] best_idx;
		logic [COLOR_W-1:0] best_color;
	} nsc_beat_t;

endpackage

[sv/nsc_cell.sv]
// One site cell of the classifier chain: holds one site, applies loads aimed
// at it and folds its distance into passing pixel beats. Uses nsc_pkg.
module nsc_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [nsc_pkg::COUNT_W-1:0] site_count,
	input  nsc_pkg::nsc_beat_t beat_i,
	output nsc_pkg::nsc_beat_t beat_o
);
	import nsc_pkg::*;

	logic [COORD_W-1:0] site_x_q;
	logic [COORD_W-1:0] site_y_q;
	logic [COLOR_W-1:0] site_color_q;

	logic load_hit;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;

	logic v_s1;
	nsc_beat_t beat_s1;
	logic [SQ_W-1:0] sqx_s1;
	logic [SQ_W-1:0] sqy_s1;

	logic [DIST_W-1:0] dist_sum;
	logic active;
	logic take;
	nsc_beat_t beat_upd;
	logic v_s2;
	nsc_beat_t beat_s2;

	assign load_hit = beat_i.valid && (beat_i.item.cmd == CMD_LOAD)
		&& (32'(beat_i.item.site_slot) == 32'(IDX));

	always_ff @(posedge clk) begin
		if (en && load_hit) begin
			site_x_q <= beat_i.item.site_x;
			site_y_q <= beat_i.item.site_y;
			site_color_q <= beat_i.item.site_color;
		end
	end

	// stage 1: absolute differences and squares
	assign dx = (beat_i.item.pixel_x >= site_x_q) ? beat_i.item.pixel_x - site_x_q
		: site_x_q - beat_i.item.pixel_x;
	assign dy = (beat_i.item.pixel_y >= site_y_q) ? beat_i.item.pixel_y - site_y_q
		: site_y_q - beat_i.item.pixel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= beat_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_s1 <= beat_i;
			sqx_s1 <= SQ_W'(dx) * SQ_W'(dx);
			sqy_s1 <= SQ_W'(dy) * SQ_W'(dy);
		end
	end

	// stage 2: sum and compare; strict less-than keeps the lower slot on ties
	assign dist_sum = DIST_W'(sqx_s1) + DIST_W'(sqy_s1);
	assign active = 32'(site_count) > 32'(IDX);
	assign take = (beat_s1.item.cmd == CMD_CLASSIFY)
		&& ((IDX == 0) || (active && (dist_sum < beat_s1.best_dist)));

	always_comb begin
		beat_upd = beat_s1;
		if (take) begin
			beat_upd.best_dist = dist_sum;
			beat_upd.best_idx = SLOT_W'(IDX);
			beat_upd.best_color = site_color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_s2 <= beat_upd;
		end
	end

	always_comb begin
		beat_o = beat_s2;
		beat_o.valid = v_s2;
	end

endmodule

[sv/nsc_out_buf.sv]
// Two-entry result buffer at the end of the cell chain; its full flag
// freezes the chain and stalls the request side. Uses nsc_pkg and the macros.
`include "nearest_site_pixel_classifier_macros.svh"

module nsc_out_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  nsc_pkg::nsc_out_t push_data,
	output logic full,
	output logic rsp_valid,
	input  logic rsp_stall,
	output nsc_pkg::nsc_out_t rsp_data
);
	import nsc_pkg::*;

	logic [1:0] cnt_q;
	nsc_out_t head_q;
	nsc_out_t tail_q;
	logic pop;

	assign pop = (cnt_q != 2'd0) && !rsp_stall;
	assign full = (cnt_q == 2'd2);
	assign rsp_valid = (cnt_q != 2'd0);
	assign rsp_data = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= (push && (cnt_q == 2'd1)) ? push_data : tail_q;
		end else if (push && (cnt_q == 2'd0)) begin
			head_q <= push_data;
		end
		if (push && !pop && (cnt_q == 2'd1)) begin
			tail_q <= push_data;
		end
	end

	`NSC_ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3)
	`NSC_ASSERT_SAME(a_no_overflow, push, cnt_q != 2'd2)
	`NSC_ASSERT_NEXT(a_push_counts, push && !pop, cnt_q == 2'($past(cnt_q) + 2'd1))
	`NSC_ASSERT_NEXT(a_pop_counts, pop && !push, cnt_q == 2'($past(cnt_q) - 2'd1))

endmodule

[sv/nearest_site_pixel_classifier.sv]
// Nearest-site pixel classifier: request beats either load a site into a
// slot or classify a pixel against sites 0 .. site_count-1.
// Request side: req_valid/req_stall/req_data; a beat moves when valid is high
// and stall is low. Load beats give no response; classify beats give one
// rsp beat with the nearest site's color, slot and squared distance (ties go
// to the lower slot). cfg_we/cfg_wdata write site_count; write it only idle.
// Each slot lives in its own cell of a chain of MAX_SITES cells; a beat moves
// through the cells in order, registered in each, so loads take effect in
// order with classifies. Throughput: one request beat per cycle while nothing
// stalls. A two-entry output buffer absorbs the response side; when it is
// full, req_stall rises and the whole chain holds until a response beat
// leaves. Reset clears the pipeline and buffer and sets site_count to 1;
// site contents are undefined until loaded.
// Depends on nsc_pkg, nsc_cell and nsc_out_buf.
module nearest_site_pixel_classifier #(
	parameter int unsigned MAX_SITES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  nsc_pkg::nsc_in_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output nsc_pkg::nsc_out_t rsp_data,
	input  logic cfg_we,
	input  logic [nsc_pkg::COUNT_W-1:0] cfg_wdata
);
	import nsc_pkg::*;

	logic [COUNT_W-1:0] site_count_q;
	logic full;
	logic en;
	logic push;
	nsc_out_t push_data;
	nsc_beat_t chain [MAX_SITES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q <= COUNT_W'(1);
		end else if (cfg_we) begin
			site_count_q <= cfg_wdata;
		end
	end

	assign en = !full;
	assign req_stall = full;

	always_comb begin
		chain[0].valid = req_valid;
		chain[0].item = req_data;
		chain[0].best_dist = '0;
		chain[0].best_idx = '0;
		chain[0].best_color = '0;
	end

	for (genvar i = 0; i < MAX_SITES; i++) begin : g_cell
		nsc_cell #(
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.site_count(site_count_q),
			.beat_i(chain[i]),
			.beat_o(chain[i+1])
		);
	end

	assign push = en && chain[MAX_SITES].valid
		&& (chain[MAX_SITES].item.cmd == CMD_CLASSIFY);

	always_comb begin
		push_data.pixel_color = chain[MAX_SITES].best_color;
		push_data.nearest_slot = chain[MAX_SITES].best_idx;
		push_data.nearest_distance = chain[MAX_SITES].best_dist;
	end

	nsc_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

endmodule
